[src/rbd_pkg.sv]
`default_nettype none

package rbd_pkg;

   localparam int ChanW      = 8;
   localparam int Lanes      = 4;
   localparam int PairW      = ChanW + 1;
   localparam int PixelW     = ChanW * Lanes;
   localparam int LineWordW  = PairW * Lanes;
   localparam int WidthRegW  = 13;
   localparam int HeightRegW = 15;
   localparam int RowW       = 14;
   localparam int HeightLimit = 16384;
   localparam int CsrAddrW   = 3;
   localparam int CsrDataW   = 32;

   localparam logic [CsrAddrW-1:0] ADDR_SOURCE_WIDTH  = 3'd0;
   localparam logic [CsrAddrW-1:0] ADDR_SOURCE_HEIGHT = 3'd4;

   typedef struct packed {
      logic width_one;
      logic height_one;
      logic load_held;
      logic line_write;
      logic line_read;
      logic emit;
      logic last;
   } step_type;

endpackage

`default_nettype wire

[src/rbd_lane.sv]
`default_nettype none

module rbd_lane (
   input  wire logic                       clock,
   input  wire logic [rbd_pkg::ChanW-1:0]  cur_chan,
   input  wire logic [rbd_pkg::ChanW-1:0]  held_chan,
   input  wire logic                       width_one,
   input  wire logic                       height_one,
   input  wire logic                       load,
   input  wire logic [rbd_pkg::PairW-1:0]  line_pair,
   output logic      [rbd_pkg::PairW-1:0]  pair,
   output logic      [rbd_pkg::ChanW-1:0]  avg
);

   logic [rbd_pkg::PairW-1:0]  pair_ff;
   logic [rbd_pkg::PairW:0]    sum;

   always_comb begin
      if (width_one) begin
         pair = {cur_chan, 1'b0};
      end else begin
         pair = {1'b0, held_chan} + {1'b0, cur_chan};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pair_ff <= pair;
      end
   end

   always_comb begin
      if (height_one) begin
         sum = {pair_ff, 1'b0};
      end else begin
         sum = {1'b0, line_pair} + {1'b0, pair_ff};
      end
      avg = sum[rbd_pkg::PairW:2];
   end

endmodule

`default_nettype wire

[src/rbd_ctrl.sv]
`default_nettype none

module rbd_ctrl #(
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [rbd_pkg::WidthRegW-1:0]         cfg_width,
   input  wire logic [rbd_pkg::HeightRegW-1:0]        cfg_height,
   input  wire logic                                  restart,
   input  wire logic                                  advance,
   output rbd_pkg::step_type                          step,
   output logic [((MAX_WIDTH + 1) / 2 > 1 ? $clog2((MAX_WIDTH + 1) / 2) : 1)-1:0] line_addr
);

   localparam int LineDepth = (MAX_WIDTH + 1) / 2;
   localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;
   localparam int WidthW    = $clog2(MAX_WIDTH + 1);
   localparam int CmpW      = (WidthW > rbd_pkg::WidthRegW) ? WidthW : rbd_pkg::WidthRegW;
   localparam int ColW      = $clog2(MAX_WIDTH);
   localparam int HW        = rbd_pkg::HeightRegW;
   localparam int RowW      = rbd_pkg::RowW;

   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;

   logic [CmpW-1:0] reg_w, eff_w, dw, col_next;
   logic [HW-1:0]   eff_h, dh, row_next, y_ext;
   logic [RowW-1:0] y;
   logic            col_wrap, row_wrap, have_pair;

   always_comb begin
      reg_w = CmpW'(cfg_width);
      priority if (reg_w == '0) begin
         eff_w = CmpW'(1);
      end else if (reg_w > CmpW'(MAX_WIDTH)) begin
         eff_w = CmpW'(MAX_WIDTH);
      end else begin
         eff_w = reg_w;
      end
      dw = eff_w >> 1;
      if (dw == '0) begin
         dw = CmpW'(1);
      end

      priority if (cfg_height == '0) begin
         eff_h = HW'(1);
      end else if (cfg_height > HW'(rbd_pkg::HeightLimit)) begin
         eff_h = HW'(rbd_pkg::HeightLimit);
      end else begin
         eff_h = cfg_height;
      end
      dh = eff_h >> 1;
      if (dh == '0) begin
         dh = HW'(1);
      end

      step.width_one  = (eff_w == CmpW'(1));
      step.height_one = (eff_h == HW'(1));
      have_pair       = step.width_one || col_ff[0];
      step.load_held  = !have_pair;
      step.line_write = have_pair && !step.height_one && !row_ff[0];
      step.line_read  = have_pair && !step.height_one && row_ff[0];
      step.emit       = have_pair && (step.height_one || row_ff[0]);

      line_addr = step.width_one ? '0 : AddrW'(col_ff >> 1);
      y         = step.height_one ? '0 : (row_ff >> 1);
      y_ext     = HW'(y);
      step.last = (CmpW'(line_addr) == dw - CmpW'(1)) && (y_ext == dh - HW'(1));

      col_next = CmpW'(col_ff) + CmpW'(1);
      row_next = HW'(row_ff) + HW'(1);
      col_wrap = (col_next >= eff_w);
      row_wrap = (row_next >= eff_h);

      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (advance) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_next[RowW-1:0];
         end else begin
            col_in = col_next[ColW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

[src/rgba_box_downsample_2x2_top.sv]
// 2x2 box-filter downsampler for RGBA8 pixels.
// Source pixels enter on the req_ channel in raster order, one request per pixel.
// The image size is set through the csr_ port: source_width at byte address 0,
// source_height at address 4. Any write to either register restarts the frame.
// Write the registers only while no request is in flight.
// For each 2x2 block one averaged pixel leaves on the rsp_ channel; rsp_tlast
// marks the last pixel of the output image. Odd sizes drop the last column or
// row, and a size of one reuses the single sample.
// Throughput is one pixel per cycle while the receiver keeps up. The averaged
// pixel for the request that carries the lower-right sample of its block passes
// through the registered read of the line store and then the output register.
// The line store holds the horizontal pair sums of an even row in one
// single-port memory of (MAX_WIDTH+1)/2 words; it is not cleared.
// Reset zeroes the counters, held pixel and valid flags; both sizes become 1.
// When the receiver stalls, the output register holds its pixel, one more
// result waits in the read stage, and req_tready drops once both are full.
`default_nettype none

module rgba_box_downsample_2x2_top #(
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
   input  wire logic [rbd_pkg::PixelW-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
   output logic      [rbd_pkg::PixelW-1:0]       rsp_tdata,
   output logic                                  rsp_tlast,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [rbd_pkg::CsrAddrW-1:0]     csr_paddr,
   input  wire logic [rbd_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic      [rbd_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   localparam int LineDepth = (MAX_WIDTH + 1) / 2;
   localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;
   localparam int ChanW     = rbd_pkg::ChanW;
   localparam int PairW     = rbd_pkg::PairW;

   logic [rbd_pkg::WidthRegW-1:0]  width_ff, width_in;
   logic [rbd_pkg::HeightRegW-1:0] height_ff, height_in;
   logic                           csr_write, restart;

   rbd_pkg::step_type              step;
   logic [AddrW-1:0]               line_addr;
   logic                           accept, advance, s1_go;

   logic [rbd_pkg::PixelW-1:0]     held_ff;
   logic [rbd_pkg::LineWordW-1:0]  line_mem [LineDepth];
   logic [rbd_pkg::LineWordW-1:0]  line_rd_ff;
   logic [rbd_pkg::LineWordW-1:0]  pair_word;
   logic [rbd_pkg::PixelW-1:0]     avg_word;

   logic                           s1_vld_ff, s1_vld_in, s1_last_ff;
   logic                           out_vld_ff, out_vld_in, out_last_ff;
   logic [rbd_pkg::PixelW-1:0]     out_data_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign restart    = csr_write && ((csr_paddr == rbd_pkg::ADDR_SOURCE_WIDTH) ||
                                     (csr_paddr == rbd_pkg::ADDR_SOURCE_HEIGHT));

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write && (csr_paddr == rbd_pkg::ADDR_SOURCE_WIDTH)) begin
         width_in = csr_pwdata[rbd_pkg::WidthRegW-1:0];
      end
      if (csr_write && (csr_paddr == rbd_pkg::ADDR_SOURCE_HEIGHT)) begin
         height_in = csr_pwdata[rbd_pkg::HeightRegW-1:0];
      end
      unique case (csr_paddr)
         rbd_pkg::ADDR_SOURCE_WIDTH:  csr_prdata = rbd_pkg::CsrDataW'(width_ff);
         rbd_pkg::ADDR_SOURCE_HEIGHT: csr_prdata = rbd_pkg::CsrDataW'(height_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rbd_pkg::WidthRegW'(1);
         height_ff <= rbd_pkg::HeightRegW'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign advance    = !out_vld_ff || rsp_tready;
   assign s1_go      = s1_vld_ff && advance;
   assign req_tready = !s1_vld_ff || advance;
   assign accept     = req_tvalid && req_tready;

   rbd_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .restart    (restart),
      .advance    (accept),
      .step       (step),
      .line_addr  (line_addr)
   );

   for (genvar g = 0; g < rbd_pkg::Lanes; g++) begin : g_lane
      rbd_lane u_lane (
         .clock      (clock),
         .cur_chan   (req_tdata[g*ChanW +: ChanW]),
         .held_chan  (held_ff[g*ChanW +: ChanW]),
         .width_one  (step.width_one),
         .height_one (step.height_one),
         .load       (accept),
         .line_pair  (line_rd_ff[g*PairW +: PairW]),
         .pair       (pair_word[g*PairW +: PairW]),
         .avg        (avg_word[g*ChanW +: ChanW])
      );
   end

   always_ff @(posedge clock) begin
      if (accept && step.line_write) begin
         line_mem[line_addr] <= pair_word;
      end
      if (accept && step.line_read) begin
         line_rd_ff <= line_mem[line_addr];
      end
   end

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = step.emit;
      end else if (s1_go) begin
         s1_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (s1_go) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (accept && step.load_held) begin
            held_ff <= req_tdata;
         end
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff <= step.last;
      end
      if (s1_go) begin
         out_data_ff <= avg_word;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      !(step.line_write && step.line_read))
      else $error("line store written and read by the same request");

   assert property (@(posedge clock) disable iff (reset)
      accept && step.emit |=> s1_vld_ff)
      else $error("emitting request did not reach the read stage");

   assert property (@(posedge clock) disable iff (reset)
      accept && !step.emit && !s1_vld_ff |=> !s1_vld_ff)
      else $error("non-emitting request created a result");

   assert property (@(posedge clock) disable iff (reset)
      s1_go |=> out_vld_ff)
      else $error("read stage result lost on the way to the output register");

endmodule

`default_nettype wire

[tb/rgba_box_downsample_2x2_top_tb.sv]
module rgba_box_downsample_2x2_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rbd_pkg::*;

   localparam int MaxWidth = 4096;
   localparam int LineDepth = (MaxWidth + 1) / 2;
   localparam int unsigned RandomItems = 800;
   localparam int DirectedRows = 35;
   localparam int PressureItems = 240;
   localparam int LongStall = 300;
   localparam int QuietLimit = 2000;

   typedef enum {DO_PIXEL, DO_WIDTH, DO_HEIGHT} step_op_e;

   typedef struct packed {
      logic [PixelW-1:0] rgba;
      logic              frame_end;
   } avg_pixel_t;

   typedef struct {
      step_op_e          op;
      logic [31:0]       value;
      bit                typed;
      logic [PixelW-1:0] want_rgba;
      logic              want_last;
   } directed_row_t;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [PixelW-1:0]   req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [PixelW-1:0]   rsp_tdata;
   logic                rsp_tlast;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   // Downsampler state as the stream has left it after the last accepted request.
   logic [LineWordW-1:0]  pair_row [LineDepth];
   logic [PixelW-1:0]     left_px;
   int unsigned           next_col;
   int unsigned           next_row;
   logic [WidthRegW-1:0]  cfg_width;
   logic [HeightRegW-1:0] cfg_height;

   avg_pixel_t  pending_averages [$];
   int          mismatches;
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   bit          stall_request;

   directed_row_t directed_rows [DirectedRows] = '{
      '{DO_PIXEL,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{DO_PIXEL,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{DO_PIXEL,  32'h8040_2010, 1'b1, 32'h8040_2010, 1'b1},
      '{DO_WIDTH,  32'h0000_0002, 1'b0, 32'h0, 1'b0},
      '{DO_HEIGHT, 32'h0000_0002, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{DO_PIXEL,  32'h0101_0101, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h0102_0300, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h0200_0001, 1'b0, 32'h0, 1'b0},
      '{DO_WIDTH,  32'hFFFF_E000, 1'b0, 32'h0, 1'b0},
      '{DO_HEIGHT, 32'hFFFF_8000, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h5AA5_C33C, 1'b1, 32'h5AA5_C33C, 1'b1},
      '{DO_WIDTH,  32'h0000_0003, 1'b0, 32'h0, 1'b0},
      '{DO_HEIGHT, 32'h0000_0003, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h1020_3040, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'hFF00_FF00, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h00FF_00FF, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h7F80_8180, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h0101_0101, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h0303_0303, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'hFEFE_FEFE, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h8080_8080, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h0F0F_0F0F, 1'b0, 32'h0, 1'b0},
      '{DO_WIDTH,  32'h0000_0001, 1'b0, 32'h0, 1'b0},
      '{DO_HEIGHT, 32'h0000_0002, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'hC0C0_C0C0, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h4141_4141, 1'b0, 32'h0, 1'b0},
      '{DO_WIDTH,  32'h0000_0002, 1'b0, 32'h0, 1'b0},
      '{DO_HEIGHT, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'h1357_9BDF, 1'b0, 32'h0, 1'b0},
      '{DO_PIXEL,  32'hECA8_6420, 1'b0, 32'h0, 1'b0}
   };

   rgba_box_downsample_2x2_top #(
      .MAX_WIDTH(MaxWidth)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned effective_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MaxWidth) return MaxWidth;
      return 32'(cfg_width);
   endfunction

   function automatic int unsigned effective_height();
      if (cfg_height == 0) return 1;
      if (cfg_height > HeightLimit) return HeightLimit;
      return 32'(cfg_height);
   endfunction

   function automatic logic [PixelW-1:0] random_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return PixelW'($urandom());
      endcase
   endfunction

   // Advances the downsampler state by one source pixel and reports the block
   // average that this pixel completes, if any.
   task automatic box_average_pixel(input logic [PixelW-1:0] px, output bit produced,
                                    output avg_pixel_t result);
      int unsigned w;
      int unsigned h;
      int unsigned dw;
      int unsigned dh;
      int unsigned x;
      int unsigned y;
      logic [PairW-1:0] pair [Lanes];
      logic [PairW:0]   total [Lanes];
      bit paired;
      bit emit;
      w = effective_width();
      h = effective_height();
      produced = 1'b0;
      result = '0;
      paired = 1'b0;
      emit = 1'b0;
      x = 0;
      y = 0;
      if (w == 1) begin
         for (int c = 0; c < Lanes; c++) pair[c] = {px[c*ChanW +: ChanW], 1'b0};
         paired = 1'b1;
      end else if (next_col % 2 == 1) begin
         for (int c = 0; c < Lanes; c++)
            pair[c] = {1'b0, left_px[c*ChanW +: ChanW]} + {1'b0, px[c*ChanW +: ChanW]};
         paired = 1'b1;
         x = next_col / 2;
      end else begin
         left_px = px;
      end
      if (paired) begin
         dw = (w / 2 > 0) ? w / 2 : 1;
         dh = (h / 2 > 0) ? h / 2 : 1;
         if (h == 1) begin
            for (int c = 0; c < Lanes; c++) total[c] = {pair[c], 1'b0};
            emit = 1'b1;
         end else if (next_row % 2 == 0) begin
            for (int c = 0; c < Lanes; c++) pair_row[x][c*PairW +: PairW] = pair[c];
         end else begin
            for (int c = 0; c < Lanes; c++)
               total[c] = {1'b0, pair_row[x][c*PairW +: PairW]} + {1'b0, pair[c]};
            emit = 1'b1;
            y = next_row / 2;
         end
         if (emit) begin
            for (int c = 0; c < Lanes; c++) result.rgba[c*ChanW +: ChanW] = total[c][PairW:2];
            result.frame_end = (x == dw - 1) && (y == dh - 1);
            produced = 1'b1;
         end
      end
      next_col++;
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
         if (next_row >= h) next_row = 0;
      end
   endtask

   task automatic send_pixel(input logic [PixelW-1:0] px, input bit typed,
                             input avg_pixel_t want);
      bit produced;
      avg_pixel_t average;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      box_average_pixel(px, produced, average);
      if (typed) pending_averages = {pending_averages, want};
      else if (produced) pending_averages = {pending_averages, average};
   endtask

   // The block must be idle before a register write; a pixel that completes no
   // block may still be in the pipeline when the last result has left.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_size(input logic [CsrAddrW-1:0] addr,
                               input logic [CsrDataW-1:0] value);
      logic [CsrDataW-1:0] stored;
      logic [CsrDataW-1:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_SOURCE_WIDTH) begin
         cfg_width = value[WidthRegW-1:0];
         stored = CsrDataW'(cfg_width);
      end else begin
         cfg_height = value[HeightRegW-1:0];
         stored = CsrDataW'(cfg_height);
      end
      next_col = 0;
      next_row = 0;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== stored) begin
         mismatches++;
         $error("register %0d readback: expected %0h, got %0h", addr, stored, readback);
      end
      @(posedge clock);
   endtask

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LongStall) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      avg_pixel_t want;
      string lane_name [Lanes];
      lane_name = '{"red", "green", "blue", "alpha"};
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_averages.size() == 0) begin
            mismatches++;
            $error("unexpected averaged pixel %h", rsp_tdata);
         end else begin
            want = pending_averages.pop_front();
            for (int c = 0; c < Lanes; c++) begin
               if (rsp_tdata[c*ChanW +: ChanW] !== want.rgba[c*ChanW +: ChanW]) begin
                  mismatches++;
                  $error("%s: expected %0d, got %0d", lane_name[c],
                         want.rgba[c*ChanW +: ChanW], rsp_tdata[c*ChanW +: ChanW]);
               end
            end
            if (rsp_tlast !== want.frame_end) begin
               mismatches++;
               $error("frame_end: expected %0d, got %0d", want.frame_end, rsp_tlast);
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) ||
             (csr_psel === 1'b1 && csr_penable === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("rgba_box_downsample_2x2_top regression: fail");
      $finish;
   end

   initial begin
      int unsigned random_items;
      int unsigned count;
      int unsigned frame_items;
      int unsigned width_pick;
      int unsigned height_pick;
      bit write_width;
      bit write_height;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      mismatches = 0;
      stall_request = 1'b0;
      sender_idle_pct = 29;
      receiver_idle_pct = 55;
      for (int i = 0; i < LineDepth; i++) pair_row[i] = '0;
      left_px = '0;
      next_col = 0;
      next_row = 0;
      cfg_width = 1;
      cfg_height = 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         case (directed_rows[i].op)
            DO_PIXEL: begin
               send_pixel(directed_rows[i].value, directed_rows[i].typed,
                          '{rgba: directed_rows[i].want_rgba,
                            frame_end: directed_rows[i].want_last});
            end
            DO_WIDTH: begin
               settle_block();
               program_size(ADDR_SOURCE_WIDTH, directed_rows[i].value);
            end
            DO_HEIGHT: begin
               settle_block();
               program_size(ADDR_SOURCE_HEIGHT, directed_rows[i].value);
            end
            default: ;
         endcase
      end

      // Part of a row at the widest size and a height of one, with the receiver
      // held off partway through so that the request side backs up.
      settle_block();
      program_size(ADDR_SOURCE_WIDTH, 32'hFFFF_FFFF);
      program_size(ADDR_SOURCE_HEIGHT, 32'h5555_8001);
      for (int i = 0; i < PressureItems; i++) begin
         if (i == 64) stall_request = 1'b1;
         send_pixel(random_pixel(), 1'b0, '0);
      end
      settle_block();
      program_size(ADDR_SOURCE_HEIGHT, 32'hFFFF_FFFF);
      program_size(ADDR_SOURCE_WIDTH, 32'h0000_0006);
      repeat (40) send_pixel(random_pixel(), 1'b0, '0);

      random_items = 0;
      while (random_items < RandomItems) begin
         if (random_items < RandomItems / 3) begin
            sender_idle_pct = 29;
            receiver_idle_pct = 55;
         end else if (random_items < 2 * RandomItems / 3) begin
            sender_idle_pct = 55;
            receiver_idle_pct = 29;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
               0: width_pick = 0;
               1: width_pick = 1;
               2: width_pick = 8191;
               default: width_pick = $urandom_range(MaxWidth, 8191);
            endcase
         end else begin
            width_pick = $urandom_range(1, 12);
         end
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
               0: height_pick = 0;
               1: height_pick = 1;
               2: height_pick = 32767;
               default: height_pick = $urandom_range(HeightLimit, 32767);
            endcase
         end else begin
            height_pick = $urandom_range(1, 8);
         end
         write_width = ($urandom_range(3) != 0);
         write_height = !write_width || ($urandom_range(3) != 0);
         settle_block();
         if (write_width)
            program_size(ADDR_SOURCE_WIDTH, ($urandom() & ~32'h1FFF) | width_pick);
         if (write_height)
            program_size(ADDR_SOURCE_HEIGHT, ($urandom() & ~32'h7FFF) | height_pick);
         frame_items = effective_width() * effective_height();
         if (frame_items > 200 || $urandom_range(4) == 0)
            count = $urandom_range(1, (frame_items < 60) ? frame_items : 60);
         else
            count = frame_items * $urandom_range(1, 3);
         if (count > RandomItems - random_items) count = RandomItems - random_items;
         repeat (count) send_pixel(random_pixel(), 1'b0, '0);
         random_items += count;
      end

      settle_block();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("rgba_box_downsample_2x2_top regression: pass");
      else
         $display("rgba_box_downsample_2x2_top regression: fail");
      $finish;
   end

endmodule
